FILE: rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
// tdpt_pkg: shared types and codes for the touch drag and pinch tracker
// used by tdpt_ctrl, tdpt_datapath and touch_drag_pinch_tracker; no dependencies

package tdpt_pkg;

   // result kind codes
   localparam logic EVENT_DRAG  = 1'b0;
   localparam logic EVENT_PINCH = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // take a new frame from the input channel
      logic square;    // square the coordinate distances
      logic load_sum;  // start the root with the sum of squares
      logic iterate;   // one root bit
      logic commit;    // update tracking state, load result if any
   } tdpt_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic new_multi;  // frame on the input port has two or more touches
      logic root_done;  // all root bits resolved
      logic commit_ok;  // frame can retire now (no result or result slot free)
   } tdpt_status_type;

endpackage

FILE: rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps
// tdpt_ctrl: sequencing state machine for the touch drag and pinch tracker
// depends on tdpt_pkg; drives tdpt_datapath through command and status structs

module tdpt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tdpt_pkg::tdpt_status_type status,
   output tdpt_pkg::tdpt_cmd_type    cmd
);
   import tdpt_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // input side is open only between frames
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.new_multi ? ST_SQUARE : ST_EMIT;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.load_sum = 1'b1;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.iterate = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tdpt_datapath.sv
`timescale 1ns / 1ps
// tdpt_datapath: frame registers, squarer, bit-serial floor root, tracking state
// and result register; depends on tdpt_pkg, sequenced by tdpt_ctrl

module tdpt_datapath #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [3:0]                      req_touch_count,
   input  logic [COORD_BITS-1:0]           req_first_x,
   input  logic [COORD_BITS-1:0]           req_first_y,
   input  logic [COORD_BITS-1:0]           req_second_x,
   input  logic [COORD_BITS-1:0]           req_second_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_kind,
   output logic signed [COORD_BITS:0]      rsp_move_x,
   output logic signed [COORD_BITS:0]      rsp_move_y,
   output logic signed [COORD_BITS+1:0]    rsp_spread_change,
   input  tdpt_pkg::tdpt_cmd_type          cmd,
   output tdpt_pkg::tdpt_status_type       status
);
   import tdpt_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int RB = CB + 1;        // root bits
   localparam int VB = 2 * RB;        // radicand and trial width
   localparam logic [VB-1:0] BIT_START = {2'b01, {(VB-2){1'b0}}};

   // frame registers
   logic [3:0]         count_ff, count_in;
   logic [CB-1:0]      x0_ff, x0_in, y0_ff, y0_in;
   logic [CB-1:0]      adx_ff, adx_in, ady_ff, ady_in;
   // squares and root
   logic [2*CB-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [VB-1:0]      rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   // tracking state
   logic [CB-1:0]      prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [RB-1:0]      prev_spread_ff, prev_spread_in;
   logic [3:0]         prev_count_ff, prev_count_in;
   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [CB:0]        mx_ff, mx_in, my_ff, my_in;
   logic [CB+1:0]      spread_ff, spread_in;

   logic [VB-1:0]      trial;
   logic [RB-1:0]      spread_now;
   logic               is_single, is_multi, drag_fire, pinch_fire, fire, out_free;

   assign trial      = root_ff + bit_ff;
   assign spread_now = root_ff[RB-1:0];
   assign is_single  = (count_ff == 4'd1);
   assign is_multi   = (count_ff >= 4'd2);
   assign drag_fire  = is_single && (prev_count_ff == 4'd1)
                       && ((x0_ff != prev_x_ff) || (y0_ff != prev_y_ff));
   assign pinch_fire = is_multi && (prev_count_ff >= 4'd2)
                       && (spread_now != prev_spread_ff);
   assign fire       = drag_fire || pinch_fire;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign status.new_multi = (req_touch_count >= 4'd2);
   assign status.root_done = (bit_ff == '0);
   assign status.commit_ok = !fire || out_free;

   // frame capture and squaring
   always_comb begin
      count_in = count_ff;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      adx_in   = adx_ff;
      ady_in   = ady_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      if (cmd.capture) begin
         count_in = req_touch_count;
         x0_in    = req_first_x;
         y0_in    = req_first_y;
         adx_in   = (req_first_x >= req_second_x) ? req_first_x - req_second_x
                                                  : req_second_x - req_first_x;
         ady_in   = (req_first_y >= req_second_y) ? req_first_y - req_second_y
                                                  : req_second_y - req_first_y;
      end
      if (cmd.square) begin
         sqx_in = (2*CB)'(adx_ff) * (2*CB)'(adx_ff);
         sqy_in = (2*CB)'(ady_ff) * (2*CB)'(ady_ff);
      end
   end

   // bit-serial floor square root, one root bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.load_sum) begin
         rem_in  = VB'(sqx_ff) + VB'(sqy_ff);
         root_in = '0;
         bit_in  = BIT_START;
      end else if (cmd.iterate) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // tracking state and result register
   always_comb begin
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      prev_spread_in = prev_spread_ff;
      prev_count_in  = prev_count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      kind_in        = kind_ff;
      mx_in          = mx_ff;
      my_in          = my_ff;
      spread_in      = spread_ff;
      if (cmd.commit) begin
         prev_count_in = count_ff;
         if (is_single) begin
            prev_x_in      = x0_ff;
            prev_y_in      = y0_ff;
            prev_spread_in = '0;
         end else if (is_multi) begin
            prev_spread_in = spread_now;
         end else begin
            prev_spread_in = '0;
         end
         if (fire) begin
            rsp_valid_in = 1'b1;
            if (drag_fire) begin
               kind_in   = EVENT_DRAG;
               mx_in     = {1'b0, x0_ff} - {1'b0, prev_x_ff};
               my_in     = {1'b0, y0_ff} - {1'b0, prev_y_ff};
               spread_in = '0;
            end else begin
               kind_in   = EVENT_PINCH;
               mx_in     = '0;
               my_in     = '0;
               spread_in = {1'b0, spread_now} - {1'b0, prev_spread_ff};
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      kind_ff   <= kind_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      spread_ff <= spread_in;
   end

   // control and tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         prev_spread_ff <= '0;
         prev_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         prev_spread_ff <= prev_spread_in;
         prev_count_ff  <= prev_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_move_x        = mx_ff;
   assign rsp_move_y        = my_ff;
   assign rsp_spread_change = spread_ff;

endmodule

FILE: rtl/touch_drag_pinch_tracker.sv
`timescale 1ns / 1ps
// touch_drag_pinch_tracker: top level of the touch drag and pinch tracker
// depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath

// One touch frame is taken at a time. A frame with zero or one touch goes
// from capture straight to the emit state, where it retires; a frame with two
// or more touches passes through squaring, summing, COORD_BITS + 1 root bits
// at one per cycle and a check that the root is finished before it reaches
// the emit state. A new frame is taken only after the previous one retires.
// Each frame gives at most one result transaction: a drag (change of the first
// point) or a pinch (change of the floor distance between the first two
// points), only when that change is nonzero. The result sits in an output
// register, so the next frame is taken while an earlier result still waits; a
// frame only waits at retirement, for as long as the output stalls, if it has
// a result and the previous one has not been taken yet.

module touch_drag_pinch_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [3:0]                   req_touch_count,
   input  logic [COORD_BITS-1:0]        req_first_x,
   input  logic [COORD_BITS-1:0]        req_first_y,
   input  logic [COORD_BITS-1:0]        req_second_x,
   input  logic [COORD_BITS-1:0]        req_second_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_event_kind,
   output logic signed [COORD_BITS:0]   rsp_move_x,
   output logic signed [COORD_BITS:0]   rsp_move_y,
   output logic signed [COORD_BITS+1:0] rsp_spread_change
);
   import tdpt_pkg::*;

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   // sequencer
   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   tdpt_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_touch_count   (req_touch_count),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_spread_change (rsp_spread_change),
      .cmd               (cmd),
      .status            (status)
   );

   // one frame in flight: an accepted transaction closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a frame is in flight");

   // a new result only appears when a frame retires
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result appeared without a frame retiring");

   // drag results carry a nonzero move and no spread change
   a_drag_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EVENT_DRAG)) |->
         ((rsp_spread_change == '0) && ((rsp_move_x != '0) || (rsp_move_y != '0))))
      else $error("malformed drag result");

   // pinch results carry a nonzero spread change and no move
   a_pinch_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EVENT_PINCH)) |->
         ((rsp_spread_change != '0) && (rsp_move_x == '0) && (rsp_move_y == '0)))
      else $error("malformed pinch result");

endmodule
